@@ src/bse_pkg.sv @@
`default_nettype none
package bse_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_LOAD,
		CM_SORT,
		CM_SHIFT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t               mode;
		logic                     phase;
		logic signed [DATA_W-1:0] data;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ src/bse_cell.sv @@
`default_nettype none
module bse_cell (
	input  wire                               clk,
	input  wire bse_pkg::cell_ctl_t           ctl,
	input  wire                               ld_en,
	input  wire                               pos_odd,
	input  wire                               up_ok,
	input  wire                               dn_ok,
	input  wire signed [bse_pkg::DATA_W-1:0]  up_val,
	input  wire signed [bse_pkg::DATA_W-1:0]  dn_val,
	input  wire                               dn_gt,
	output logic signed [bse_pkg::DATA_W-1:0] val,
	output logic                              gt_up,
	output logic                              swp
);
	import bse_pkg::*;

	logic signed [DATA_W-1:0] val_q;
	logic                     pair_up;

	assign val     = val_q;
	assign gt_up   = val_q > up_val;
	assign pair_up = (pos_odd == ctl.phase);
	assign swp     = (ctl.mode == CM_SORT) && pair_up && up_ok && gt_up;

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CM_LOAD: begin
				if (ld_en) val_q <= ctl.data;
			end
			CM_SORT: begin
				if (pair_up) begin
					if (up_ok && gt_up) val_q <= up_val;
				end else begin
					if (dn_ok && dn_gt) val_q <= dn_val;
				end
			end
			CM_SHIFT: val_q <= up_val;
			default: val_q <= val_q;
		endcase
	end

endmodule
`default_nettype wire

@@ src/bubble_sort_engine_unit.sv @@
// Sorting engine for sets of up to 64 signed 32-bit values.
// Input: pulse start with value and last while busy is low; one beat is
// taken per cycle. Beats past the 64th of a set are dropped, but a last
// flag on such a beat still closes the set.
// After the beat with last, busy rises and the row of cells runs
// alternating even/odd compare-and-swap phases, one phase per cycle, until
// two phases in a row make no swap.
// Output: valid marks one result beat per cycle on sorted_value, ascending,
// n beats back to back; end_of_set marks the final (largest) one. The
// receiver cannot stall, so results are never held.
// busy drops in the cycle after the final beat; a new set may start then.
// Reset (arst_n low) empties the set and returns to loading; stored values
// are not cleared.
`default_nettype none
module bubble_sort_engine_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire signed [bse_pkg::DATA_W-1:0]  value,
	input  wire                               last,
	output logic                              valid,
	output logic signed [bse_pkg::DATA_W-1:0] sorted_value,
	output logic                              end_of_set
);
	import bse_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             phase_q;
	logic             quiet_q;
	cell_mode_t       mode;
	cell_ctl_t        ctl;
	logic             accept;
	logic             any_swap;

	logic signed [DATA_W-1:0] cval [DEPTH];
	logic [DEPTH-1:0]         gt;
	logic [DEPTH-1:0]         swp;
	logic [DEPTH-1:0]         pair_ok;

	assign accept   = start && !busy;
	assign any_swap = |swp;

	assign ctl.mode  = mode;
	assign ctl.phase = phase_q;
	assign ctl.data  = value;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && last) state_d = ST_SORT;
			end
			ST_SORT: begin
				if (!any_swap && quiet_q) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (count_q == CNT_W'(1)) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		busy  = 1'b1;
		valid = 1'b0;
		mode  = CM_HOLD;
		case (state_q)
			ST_LOAD: begin
				busy = 1'b0;
				if (start) mode = CM_LOAD;
			end
			ST_SORT: mode = CM_SORT;
			ST_EMIT: begin
				valid = 1'b1;
				mode  = CM_SHIFT;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			phase_q <= 1'b0;
			quiet_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					phase_q <= 1'b0;
					quiet_q <= 1'b0;
					if (accept && count_q < CNT_W'(DEPTH)) count_q <= count_q + CNT_W'(1);
				end
				ST_SORT: begin
					phase_q <= !phase_q;
					quiet_q <= !any_swap;
				end
				ST_EMIT: begin
					count_q <= count_q - CNT_W'(1);
				end
				default: count_q <= '0;
			endcase
		end
	end

	assign sorted_value = cval[0];
	assign end_of_set   = valid && (count_q == CNT_W'(1));

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic signed [DATA_W-1:0] up_v;
			logic signed [DATA_W-1:0] dn_v;
			logic                     dn_g;
			logic                     dn_k;

			if (i == DEPTH - 1) begin : g_top
				assign pair_ok[i] = 1'b0;
				assign up_v       = '0;
			end else begin : g_mid
				assign pair_ok[i] = CNT_W'(i + 1) < count_q;
				assign up_v       = cval[i+1];
			end

			if (i == 0) begin : g_bot
				assign dn_v = '0;
				assign dn_g = 1'b0;
				assign dn_k = 1'b0;
			end else begin : g_upper
				assign dn_v = cval[i-1];
				assign dn_g = gt[i-1];
				assign dn_k = pair_ok[i-1];
			end

			bse_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.ld_en   (count_q == CNT_W'(i)),
				.pos_odd (1'(i % 2)),
				.up_ok   (pair_ok[i]),
				.dn_ok   (dn_k),
				.up_val  (up_v),
				.dn_val  (dn_v),
				.dn_gt   (dn_g),
				.val     (cval[i]),
				.gt_up   (gt[i]),
				.swp     (swp[i])
			);
		end
	endgenerate

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> count_q != '0)
		else $error("result beat with empty set");

	a_emit_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !end_of_set |=> valid)
		else $error("gap inside result burst");

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !end_of_set |=> $signed($past(sorted_value)) <= sorted_value)
		else $error("results out of order");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> busy)
		else $error("set closed without sorting");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		end_of_set |=> !busy && count_q == '0)
		else $error("not idle after final beat");

endmodule
`default_nettype wire

@@ verif/bubble_sort_engine_unit_tb.sv @@
`timescale 1ns / 1ps

module bubble_sort_engine_unit_tb;
	import bse_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
	localparam int PHASE_BEATS    = 98;
	localparam int REPORT_LIMIT   = 10;

	typedef logic signed [DATA_W-1:0] word_t;

	class sorted_set_tracker;
		word_t held[$];
		word_t expected_values[$];
		logic  expected_ends[$];
		int    mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return expected_values.size();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		// ascending bubble passes, stop after a pass with no swap
		function void sort_held();
			int    i;
			word_t t;
			bit    swapped;
			swapped = 1'b1;
			while (swapped) begin
				swapped = 1'b0;
				for (i = 0; i + 1 < held.size(); i++) begin
					if (held[i] > held[i + 1]) begin
						t           = held[i];
						held[i]     = held[i + 1];
						held[i + 1] = t;
						swapped     = 1'b1;
					end
				end
			end
		endfunction

		function void note_beat(word_t v, logic l);
			int k;
			if (held.size() < DEPTH) begin
				held.push_back(v);
			end
			if (l) begin
				sort_held();
				for (k = 0; k < held.size(); k++) begin
					expected_values.push_back(held[k]);
					expected_ends.push_back(k + 1 == held.size());
				end
				held.delete();
			end
		endfunction

		function void check_result(word_t v, logic e);
			word_t exp_v;
			logic  exp_e;
			if (expected_values.size() == 0) begin
				report($sformatf("unexpected result value=%0d end=%0b", v, e));
				return;
			end
			exp_v = expected_values.pop_front();
			exp_e = expected_ends.pop_front();
			if (v !== exp_v) begin
				report($sformatf("sorted_value expected %0d got %0d", exp_v, v));
			end
			if (e !== exp_e) begin
				report($sformatf("end_of_set expected %0b got %0b (value %0d)", exp_e, e, exp_v));
			end
		endfunction
	endclass

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	word_t value;
	logic  last;
	logic  valid;
	word_t sorted_value;
	logic  end_of_set;

	sorted_set_tracker tracker;
	int idle_pct;
	int stored_beats;
	int stall_cycles;

	bubble_sort_engine_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.last         (last),
		.valid        (valid),
		.sorted_value (sorted_value),
		.end_of_set   (end_of_set)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				tracker.note_beat(value, last);
			end
			if (valid) begin
				tracker.check_result(sorted_value, end_of_set);
			end
			if ((start && !busy) || valid) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic drive_beat(input word_t v, input logic l);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		value <= v;
		last  <= l;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drive_set(input int len, input int flavor);
		int    i;
		word_t v;
		word_t base;
		base = $urandom;
		for (i = 0; i < len; i++) begin
			case (flavor)
				0: v = $urandom;
				1: v = word_t'($urandom_range(8)) - 4;
				2: begin
					case ($urandom_range(3))
						0: v = 32'sh8000_0000 + word_t'($urandom_range(2));
						1: v = 32'sh7fff_ffff - word_t'($urandom_range(2));
						2: v = 0;
						default: v = -1;
					endcase
				end
				default: v = base - word_t'(i * $urandom_range(1000));
			endcase
			drive_beat(v, i == len - 1);
			if (i < DEPTH) begin
				stored_beats++;
			end
		end
	endtask

	initial begin
		int phase;
		int len;
		tracker      = new();
		stall_cycles = 0;
		stored_beats = 0;
		idle_pct     = 0;
		arst_n       = 1'b0;
		start        <= 1'b0;
		value        <= '0;
		last         <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single values at the extremes, then sets of two and five values
		drive_beat(32'sh7fff_ffff, 1'b1);
		drive_beat(32'sh8000_0000, 1'b1);
		drive_beat(0, 1'b0);
		drive_beat(-1, 1'b1);
		drive_beat(32'sh7fff_ffff, 1'b0);
		drive_beat(32'sh8000_0000, 1'b0);
		drive_beat(0, 1'b0);
		drive_beat(-1, 1'b0);
		drive_beat(1, 1'b1);
		// already in order
		drive_beat(-2, 1'b0);
		drive_beat(-1, 1'b0);
		drive_beat(1, 1'b0);
		drive_beat(2, 1'b1);
		// reverse order
		drive_beat(300, 1'b0);
		drive_beat(200, 1'b0);
		drive_beat(-100, 1'b0);
		drive_beat(-400, 1'b1);
		// equal values stay put
		drive_beat(7, 1'b0);
		drive_beat(7, 1'b0);
		drive_beat(-7, 1'b0);
		drive_beat(7, 1'b1);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				1: idle_pct = 75;
				3: idle_pct = 17;
				default: idle_pct = 0;
			endcase
			stored_beats = 0;
			// full set first, often with dropped beats and a dropped last
			drive_set($urandom_range(DEPTH, DEPTH + 4), $urandom_range(3));
			while (stored_beats < PHASE_BEATS) begin
				if ($urandom_range(11) == 0) begin
					len = $urandom_range(DEPTH - 4, DEPTH + 6);
				end else begin
					len = $urandom_range(1, 12);
				end
				drive_set(len, $urandom_range(3));
			end
		end
		start <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
